// ===== rtl/coem_pkg.sv =====
package coem_pkg;

	localparam int LABELS     = 4;
	localparam int LANES      = 4;
	localparam int MAX_DEGREE = 4096;

	localparam int WEIGHT_W  = 16;
	localparam int PROB_W    = 16;
	localparam int KEEP_W    = 17;
	localparam int Q16_FRAC  = 16;

	localparam logic [PROB_W-1:0] ONE_Q15    = 16'd32768;
	localparam logic [KEEP_W-1:0] ONE_Q16    = 17'd65536;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 17'd9830;

	localparam longint unsigned W_LIMIT_VAL = longint'(MAX_DEGREE) * 65535;

	localparam int WT_W   = $clog2(W_LIMIT_VAL + 1);
	localparam int PROD_W = WEIGHT_W + PROB_W;
	localparam int SUM_W  = WT_W + PROB_W - 1;
	localparam int Q_W    = 17;
	localparam int DEN_W  = WT_W + Q_W - 1;
	localparam int STEP_W = $clog2(Q_W);
	localparam int MIX_W  = KEEP_W + PROB_W + 1;

	localparam logic [WT_W-1:0]  W_LIMIT = WT_W'(W_LIMIT_VAL);
	localparam logic [SUM_W-1:0] S_LIMIT = SUM_W'(W_LIMIT_VAL * 32768);

	typedef struct packed {
		logic [WEIGHT_W-1:0] edge_weight;
		logic [PROB_W-1:0]   nbr_prob_0;
		logic [PROB_W-1:0]   nbr_prob_1;
		logic [PROB_W-1:0]   nbr_prob_2;
		logic [PROB_W-1:0]   nbr_prob_3;
		logic                last_edge;
		logic                is_seed;
		logic [PROB_W-1:0]   own_prob_0;
		logic [PROB_W-1:0]   own_prob_1;
		logic [PROB_W-1:0]   own_prob_2;
		logic [PROB_W-1:0]   own_prob_3;
	} coem_in_t;

	typedef struct packed {
		logic [PROB_W-1:0] new_prob_0;
		logic [PROB_W-1:0] new_prob_1;
		logic [PROB_W-1:0] new_prob_2;
		logic [PROB_W-1:0] new_prob_3;
		logic              left_unchanged;
	} coem_out_t;

	typedef enum logic [1:0] {
		ST_ACC,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} coem_state_t;

	typedef struct packed {
		logic acc;
		logic last;
		logic div_step;
		logic mul;
	} coem_lane_ctl_t;

	function automatic logic [PROB_W-1:0] clamp_prob(input logic [PROB_W-1:0] p);
		return (p > ONE_Q15) ? ONE_Q15 : p;
	endfunction

endpackage

// ===== rtl/coem_lane.sv =====
module coem_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_fire,
	input  logic [coem_pkg::WEIGHT_W-1:0]  weight,
	input  logic [coem_pkg::PROB_W-1:0]    nbr_prob,
	input  logic [coem_pkg::PROB_W-1:0]    own_prob,
	input  logic [coem_pkg::KEEP_W-1:0]    keep,
	input  coem_pkg::coem_lane_ctl_t       ctl,
	input  logic [coem_pkg::DEN_W-1:0]     dsh,
	output logic [coem_pkg::PROB_W-1:0]    mix,
	output logic [coem_pkg::PROB_W-1:0]    own
);
	import coem_pkg::*;

	logic [PROD_W-1:0]        prod_s1;
	logic [PROB_W-1:0]        own_s1;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         rem_q;
	logic [Q_W-1:0]           quo_q;
	logic [KEEP_W+PROB_W-1:0] pa_q;
	logic [KEEP_W+PROB_W-1:0] pb_q;
	logic [SUM_W:0]           sum_wide;
	logic [SUM_W-1:0]         sum_next;
	logic                     ge;
	logic [PROB_W-1:0]        avg;
	logic [KEEP_W-1:0]        keep_inv;
	logic [MIX_W-1:0]         mix_sum;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prod_s1 <= PROD_W'(weight * clamp_prob(nbr_prob));
			own_s1  <= clamp_prob(own_prob);
		end
	end

	always_comb begin
		sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(prod_s1);
		sum_next = (sum_wide > (SUM_W+1)'(S_LIMIT)) ? S_LIMIT : sum_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= ctl.last ? '0 : sum_next;
		end
	end

	// Restoring division, one quotient bit per step, divisor pre-shifted by the controller.
	assign ge = {{(DEN_W-SUM_W){1'b0}}, rem_q} >= dsh;

	always_ff @(posedge clk) begin
		if (ctl.acc && ctl.last) begin
			rem_q <= sum_next;
		end else if (ctl.div_step) begin
			if (ge) begin
				rem_q <= rem_q - dsh[SUM_W-1:0];
			end
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	always_comb begin
		avg      = (quo_q[Q_W-1] || (quo_q[PROB_W-1:0] > ONE_Q15)) ? ONE_Q15 : quo_q[PROB_W-1:0];
		keep_inv = ONE_Q16 - keep;
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			pa_q <= (KEEP_W+PROB_W)'(keep * own_s1);
			pb_q <= (KEEP_W+PROB_W)'(keep_inv * avg);
		end
	end

	always_comb begin
		mix_sum = MIX_W'(pa_q) + MIX_W'(pb_q);
		mix     = mix_sum[Q16_FRAC+PROB_W-1:Q16_FRAC];
		own     = own_s1;
	end

endmodule

// ===== rtl/coem_ctrl.sv =====
module coem_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_fire,
	input  logic                           in_last,
	input  logic                           in_seed,
	input  logic [coem_pkg::WEIGHT_W-1:0]  in_weight,
	input  logic                           out_free,
	output logic                           in_ready,
	output coem_pkg::coem_lane_ctl_t       ctl,
	output logic [coem_pkg::DEN_W-1:0]     dsh,
	output logic                           pass,
	output logic                           load
);
	import coem_pkg::*;

	coem_state_t          state_q;
	coem_state_t          state_next;
	logic                 valid_s1;
	logic                 last_s1;
	logic                 seed_s1;
	logic [WEIGHT_W-1:0]  weight_s1;
	logic [WT_W-1:0]      wt_q;
	logic [WT_W:0]        wt_wide;
	logic [WT_W-1:0]      wt_next;
	logic [DEN_W-1:0]     dsh_q;
	logic [STEP_W-1:0]    step_q;
	logic                 pass_q;
	logic                 close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
			last_s1  <= in_fire & in_last;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			seed_s1   <= in_seed;
			weight_s1 <= in_weight;
		end
	end

	always_comb begin
		wt_wide = (WT_W+1)'(wt_q) + (WT_W+1)'(weight_s1);
		wt_next = (wt_wide > (WT_W+1)'(W_LIMIT)) ? W_LIMIT : wt_wide[WT_W-1:0];
		close   = valid_s1 & last_s1;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_ACC: begin
				if (close) begin
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(Q_W - 1)) begin
					state_next = ST_MUL;
				end
			end
			ST_MUL: begin
				state_next = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_next = ST_ACC;
				end
			end
			default: begin
				state_next = ST_ACC;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		ctl.acc      = valid_s1;
		ctl.last     = last_s1;
		ctl.div_step = 1'b0;
		ctl.mul      = 1'b0;
		load         = 1'b0;
		case (state_q)
			ST_ACC: begin
				in_ready = ~close;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
			end
			ST_OUT: begin
				load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			wt_q    <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (valid_s1) begin
				wt_q <= last_s1 ? '0 : wt_next;
			end
			if (state_q == ST_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			dsh_q  <= {wt_next, {(Q_W-1){1'b0}}};
			pass_q <= seed_s1 || (wt_next == '0);
		end else if (state_q == ST_DIV) begin
			dsh_q <= dsh_q >> 1;
		end
	end

	assign dsh  = dsh_q;
	assign pass = pass_q;

endmodule

// ===== rtl/coem_merge.sv =====
module coem_merge (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           load,
	input  logic                                           pass,
	input  logic [coem_pkg::LANES-1:0][coem_pkg::PROB_W-1:0] mix,
	input  logic [coem_pkg::LANES-1:0][coem_pkg::PROB_W-1:0] own,
	input  logic                                           out_ready,
	output logic                                           out_valid,
	output coem_pkg::coem_out_t                            out_data,
	output logic                                           out_free
);
	import coem_pkg::*;

	logic                           valid_q;
	coem_out_t                      data_q;
	logic [LANES-1:0][PROB_W-1:0]   pick;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			pick[i] = pass ? own[i] : mix[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q.new_prob_0     <= pick[0];
			data_q.new_prob_1     <= pick[1];
			data_q.new_prob_2     <= pick[2];
			data_q.new_prob_3     <= pick[3];
			data_q.left_unchanged <= pass;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_free  = ~valid_q | out_ready;

endmodule

// ===== rtl/coem_label_propagation_update.sv =====
// Edge transfers of one vertex stream back to back. A last-edge transfer produces its result
// through one product stage, one accumulate stage, 17 steps of the per-lane restoring
// divider, one blend multiply stage and the output register. The next edge is taken once
// the result is loaded for output. Asynchronous active-low reset clears the lane sums,
// the weight total, the handshake state and sets the keep factor to 9830 (0.15).
module coem_label_propagation_update (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  coem_pkg::coem_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output coem_pkg::coem_out_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [coem_pkg::KEEP_W-1:0]         cfg_data
);
	import coem_pkg::*;

	logic [KEEP_W-1:0]             keep_q;
	logic [KEEP_W-1:0]             keep;
	logic                          in_fire;
	coem_lane_ctl_t                ctl;
	logic [DEN_W-1:0]              dsh;
	logic                          pass;
	logic                          load;
	logic                          out_free;
	logic [LANES-1:0][PROB_W-1:0]  nbr;
	logic [LANES-1:0][PROB_W-1:0]  own_in;
	logic [LANES-1:0][PROB_W-1:0]  mix;
	logic [LANES-1:0][PROB_W-1:0]  own;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (cfg_valid) begin
			keep_q <= cfg_data;
		end
	end

	assign keep    = (keep_q > ONE_Q16) ? ONE_Q16 : keep_q;
	assign in_fire = in_valid & in_ready;

	assign nbr[0]    = in_data.nbr_prob_0;
	assign nbr[1]    = in_data.nbr_prob_1;
	assign nbr[2]    = in_data.nbr_prob_2;
	assign nbr[3]    = in_data.nbr_prob_3;
	assign own_in[0] = in_data.own_prob_0;
	assign own_in[1] = in_data.own_prob_1;
	assign own_in[2] = in_data.own_prob_2;
	assign own_in[3] = in_data.own_prob_3;

	coem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_last   (in_data.last_edge),
		.in_seed   (in_data.is_seed),
		.in_weight (in_data.edge_weight),
		.out_free  (out_free),
		.in_ready  (in_ready),
		.ctl       (ctl),
		.dsh       (dsh),
		.pass      (pass),
		.load      (load)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		if (i < LABELS) begin : g_used
			coem_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_fire  (in_fire),
				.weight   (in_data.edge_weight),
				.nbr_prob (nbr[i]),
				.own_prob (own_in[i]),
				.keep     (keep),
				.ctl      (ctl),
				.dsh      (dsh),
				.mix      (mix[i]),
				.own      (own[i])
			);
		end else begin : g_unused
			assign mix[i] = '0;
			assign own[i] = '0;
		end
	end

	coem_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.pass      (pass),
		.mix       (mix),
		.own       (own),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_free  (out_free)
	);

endmodule

// ===== rtl/coem_checker.sv =====
module coem_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input coem_pkg::coem_in_t   in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input coem_pkg::coem_out_t  out_data
);
	import coem_pkg::*;

	// A last edge closes the vertex, so no edge of the next vertex follows directly.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_edge |=> !in_ready)
		else $error("edge transfer accepted right after a last edge");

	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.new_prob_0 <= ONE_Q15) && (out_data.new_prob_1 <= ONE_Q15) &&
			(out_data.new_prob_2 <= ONE_Q15) && (out_data.new_prob_3 <= ONE_Q15))
		else $error("result probability above one");

	// A new result only appears while the input side is held off.
	a_result_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while edges were being accepted");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

endmodule

bind coem_label_propagation_update coem_checker u_coem_checker (.*);
